### hw/rtl/bums_pkg.sv
`timescale 1ns / 1ps

package bums_pkg;

  // Fixed widths of the channel fields
  localparam int FIELD_W = 32;
  localparam int MODE_W  = 2;

  // Defaults for the top-level parameters
  localparam int MAX_ITEMS_DEF = 64;
  localparam int KEY_WIDTH_DEF = 32;

  // Bit positions inside compare_mode
  localparam int MODE_SIGNED_BIT = 0;
  localparam int MODE_DESC_BIT   = 1;

  typedef logic [MODE_W-1:0] mode_t;

  typedef struct packed {
    logic [FIELD_W-1:0] key;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] sorted_key;
    logic               final_res;
    logic               overflowed;
  } out_word_t;

endpackage

### hw/rtl/bottom_up_merge_sorter_core.sv
`timescale 1ns / 1ps

// Bottom-up merge sorter. Keys are taken one per cycle and stored until a word
// marked last arrives; the input then stalls until the last sorted word has
// been placed in the output register. For a set of n keys the sort makes
// ceil(log2 n) passes; each pass has a setup step per run pair (or lone run
// copied across) and one more at its end, and a single merge unit writes one
// key per cycle into the other of two ping-pong RAMs while reading both run
// heads from the two read ports of the source RAM. Emitting then gives one key
// per cycle when the output is not stalled. Keys past capacity are dropped and
// flagged on every output word of the set; compare_mode may be written only
// while the block is idle.

module bottom_up_merge_sorter_core #(
  parameter int MAX_ITEMS = bums_pkg::MAX_ITEMS_DEF,
  parameter int KEY_WIDTH = bums_pkg::KEY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bums_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output bums_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  bums_pkg::mode_t     cfg_data
);

  import bums_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = CW + 2;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_MERGE = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          src_r, src_nxt;
  mode_t         mode_r, mode_nxt;
  logic [CW:0]   w_r, w_nxt;
  logic [CW-1:0] base_r, base_nxt;
  logic [CW-1:0] l_r, l_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] r_r, r_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] d_r, d_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_word_r, out_word_nxt;

  logic                 in_acc;
  logic [KEY_WIDTH-1:0] in_key;
  logic [SW-1:0]        sum_mid;
  logic [SW-1:0]        sum_hi;
  logic                 l_act;
  logic                 r_act;
  logic                 r_first;
  logic                 take_r;
  logic                 out_free;

  logic                 wr0_en, wr1_en;
  logic [AW-1:0]        wr0_addr, wr1_addr;
  logic [KEY_WIDTH-1:0] wr0_data, wr1_data;
  logic [KEY_WIDTH-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
  logic [KEY_WIDTH-1:0] rd_l, rd_r;
  logic [KEY_WIDTH-1:0] merge_key;

  assign in_stall  = state_r != ST_LOAD;
  assign in_acc    = in_valid && !in_stall;
  assign in_key    = KEY_WIDTH'(in_word.key);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Port a always tracks l_r, port b tracks r_r; the read data is registered
  assign rd_l = src_r ? rd1_a : rd0_a;
  assign rd_r = src_r ? rd1_b : rd0_b;

  assign l_act     = l_r < mid_r;
  assign r_act     = r_r < hi_r;
  assign take_r    = r_act && (!l_act || r_first);
  assign merge_key = take_r ? rd_r : rd_l;

  assign sum_mid = SW'(base_r) + SW'(w_r);
  assign sum_hi  = SW'(base_r) + SW'({w_r, 1'b0});

  bums_cmp #(
    .KEY_WIDTH(KEY_WIDTH)
  ) u_cmp (
    .mode    (mode_r),
    .key_a   (rd_r),
    .key_b   (rd_l),
    .a_first (r_first)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    src_nxt       = src_r;
    mode_nxt      = mode_r;
    w_nxt         = w_r;
    base_nxt      = base_r;
    l_nxt         = l_r;
    mid_nxt       = mid_r;
    r_nxt         = r_r;
    hi_nxt        = hi_r;
    d_nxt         = d_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    if (cfg_valid && cfg_ready) begin
      mode_nxt = cfg_data;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CW'(MAX_ITEMS)) begin
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_word.last) begin
            state_nxt = ST_SETUP;
            w_nxt     = (CW + 1)'(1);
            base_nxt  = '0;
            src_nxt   = 1'b0;
          end
        end
      end
      ST_SETUP: begin
        if (w_r >= (CW + 1)'(cnt_r)) begin
          // Sorted: start emitting from the source side
          state_nxt = ST_EMIT;
          l_nxt     = '0;
        end else if (base_r >= cnt_r) begin
          // Pass done: swap RAMs, double run width
          w_nxt    = {w_r[CW-1:0], 1'b0};
          base_nxt = '0;
          src_nxt  = ~src_r;
        end else begin
          if (sum_mid > SW'(cnt_r)) begin
            mid_nxt = cnt_r;
          end else begin
            mid_nxt = sum_mid[CW-1:0];
          end
          if (sum_hi > SW'(cnt_r)) begin
            hi_nxt = cnt_r;
          end else begin
            hi_nxt = sum_hi[CW-1:0];
          end
          l_nxt     = base_r;
          r_nxt     = mid_nxt;
          d_nxt     = base_r;
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        d_nxt = d_r + 1'b1;
        if (take_r) begin
          r_nxt = r_r + 1'b1;
        end else begin
          l_nxt = l_r + 1'b1;
        end
        if ((CW + 1)'(d_r) + 1'b1 == (CW + 1)'(hi_r)) begin
          base_nxt  = hi_r;
          state_nxt = ST_SETUP;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.sorted_key   = FIELD_W'(rd_l);
          out_word_nxt.overflowed   = ovf_r;
          out_word_nxt.final_res    = 1'b0;
          l_nxt                     = l_r + 1'b1;
          if ((CW + 1)'(l_r) + 1'b1 == (CW + 1)'(cnt_r)) begin
            out_word_nxt.final_res = 1'b1;
            cnt_nxt                = '0;
            ovf_nxt                = 1'b0;
            state_nxt              = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Load goes to RAM 0; a merge writes the RAM that is not the source
  always_comb begin
    wr0_en   = 1'b0;
    wr0_addr = d_r[AW-1:0];
    wr0_data = merge_key;
    wr1_en   = (state_r == ST_MERGE) && !src_r;
    wr1_addr = d_r[AW-1:0];
    wr1_data = merge_key;
    if (state_r == ST_LOAD) begin
      wr0_en   = in_acc && (cnt_r < CW'(MAX_ITEMS));
      wr0_addr = cnt_r[AW-1:0];
      wr0_data = in_key;
    end else if (state_r == ST_MERGE) begin
      wr0_en = src_r;
    end
  end

  bums_mem #(
    .DEPTH(MAX_ITEMS),
    .WIDTH(KEY_WIDTH)
  ) u_mem0 (
    .clk       (clk),
    .wr_en     (wr0_en),
    .wr_addr   (wr0_addr),
    .wr_data   (wr0_data),
    .rd_addr_a (l_nxt[AW-1:0]),
    .rd_addr_b (r_nxt[AW-1:0]),
    .rd_data_a (rd0_a),
    .rd_data_b (rd0_b)
  );

  bums_mem #(
    .DEPTH(MAX_ITEMS),
    .WIDTH(KEY_WIDTH)
  ) u_mem1 (
    .clk       (clk),
    .wr_en     (wr1_en),
    .wr_addr   (wr1_addr),
    .wr_data   (wr1_data),
    .rd_addr_a (l_nxt[AW-1:0]),
    .rd_addr_b (r_nxt[AW-1:0]),
    .rd_data_a (rd1_a),
    .rd_data_b (rd1_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      src_r       <= 1'b0;
      mode_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      src_r       <= src_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    base_r     <= base_nxt;
    l_r        <= l_nxt;
    mid_r      <= mid_nxt;
    r_r        <= r_nxt;
    hi_r       <= hi_nxt;
    d_r        <= d_nxt;
    out_word_r <= out_word_nxt;
  end

  // A merge cycle always has a key left to move
  a_merge_has_key: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MERGE |-> (l_r < mid_r) || (r_r < hi_r))
    else $error("merge cycle with both runs exhausted");

  // Write pointer equals the run base plus the keys taken from both runs
  a_merge_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MERGE |->
      (CW + 1)'(d_r) + (CW + 1)'(mid_r) == (CW + 1)'(l_r) + (CW + 1)'(r_r))
    else $error("merge write pointer out of step with read pointers");

  // Emit never runs past the stored set
  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> (l_r < cnt_r) && (cnt_r != '0))
    else $error("emit index beyond stored keys");

  // Fill count never exceeds capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ITEMS))
    else $error("load count beyond capacity");

endmodule

### hw/rtl/bums_mem.sv
`timescale 1ns / 1ps

module bums_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

### hw/rtl/bums_cmp.sv
`timescale 1ns / 1ps

module bums_cmp #(
  parameter int KEY_WIDTH = 32
) (
  input  bums_pkg::mode_t        mode,
  input  logic [KEY_WIDTH-1:0]   key_a,
  input  logic [KEY_WIDTH-1:0]   key_b,
  output logic                   a_first
);

  import bums_pkg::*;

  logic [KEY_WIDTH-1:0] a_x;
  logic [KEY_WIDTH-1:0] b_x;

  // Flip the sign bit so signed order becomes unsigned order
  always_comb begin
    a_x = key_a;
    b_x = key_b;
    if (mode[MODE_SIGNED_BIT]) begin
      a_x[KEY_WIDTH-1] = ~key_a[KEY_WIDTH-1];
      b_x[KEY_WIDTH-1] = ~key_b[KEY_WIDTH-1];
    end
    if (mode[MODE_DESC_BIT]) begin
      a_first = a_x > b_x;
    end else begin
      a_first = a_x < b_x;
    end
  end

endmodule

### bench/bottom_up_merge_sorter_core_test.sv
`timescale 1ns / 1ps

module bottom_up_merge_sorter_core_test;
  import bums_pkg::*;

  localparam int CAP           = MAX_ITEMS_DEF;
  localparam int KEY_W         = KEY_WIDTH_DEF;
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 1200;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_KEYS   = 80;

  localparam mode_t MODE_UNSIGNED_ASC  = 2'd0;
  localparam mode_t MODE_SIGNED_ASC    = 2'd1;
  localparam mode_t MODE_UNSIGNED_DESC = 2'd2;
  localparam mode_t MODE_SIGNED_DESC   = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  mode_t     cfg_data  = '0;

  // Sorter shadow: keys loaded so far, drop flag and compare mode
  logic [FIELD_W-1:0] held_keys[$];
  logic               keys_dropped = 1'b0;
  mode_t              sort_mode    = MODE_UNSIGNED_ASC;
  out_word_t          pending_words[$];

  bit       tx_gaps = 1'b0;
  bit       rx_gaps = 1'b0;
  bit       hold_request = 1'b0;
  int       hold_left = 0;
  int       rx_gap_left = 0;
  int       mismatches = 0;
  int       words_checked = 0;
  int       keys_sent = 0;
  int       sets_sent = 0;
  int       overflow_sets = 0;
  int       quiet_cycles = 0;
  bit [3:0] modes_used = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bottom_up_merge_sorter_core #(
    .MAX_ITEMS(CAP),
    .KEY_WIDTH(KEY_W)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  function automatic bit key_precedes(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
    // flip the sign bit so signed order becomes unsigned order
    if (sort_mode[MODE_SIGNED_BIT]) begin
      a[KEY_W-1] = ~a[KEY_W-1];
      b[KEY_W-1] = ~b[KEY_W-1];
    end
    if (sort_mode[MODE_DESC_BIT])
      return a > b;
    return a < b;
  endfunction

  // Load one key; on the last one, sort stably and queue the words to come
  task automatic load_and_sort(input logic [FIELD_W-1:0] data, input logic is_last);
    logic [FIELD_W-1:0] run[$];
    logic [FIELD_W-1:0] k;
    out_word_t          w;
    int                 j;
    if (held_keys.size() < CAP)
      held_keys.push_back(data);
    else
      keys_dropped = 1'b1;
    if (!is_last)
      return;
    run = held_keys;
    for (int i = 1; i < run.size(); i++) begin
      k = run[i];
      j = i;
      while (j > 0 && key_precedes(k, run[j-1])) begin
        run[j] = run[j-1];
        j--;
      end
      run[j] = k;
    end
    for (int i = 0; i < run.size(); i++) begin
      w.sorted_key = run[i];
      w.final_res  = (i == run.size() - 1);
      w.overflowed = keys_dropped;
      pending_words.push_back(w);
    end
    if (keys_dropped)
      overflow_sets++;
    held_keys.delete();
    keys_dropped = 1'b0;
  endtask

  function automatic logic [FIELD_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          3: return 32'h7FFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      // narrow pool on both sides of the sign bit to force ties
      1, 2: return ($urandom_range(0, 1) ? 32'hFFFF_FFF0 : 32'h0000_0010) + $urandom_range(0, 2);
      default: return $urandom;
    endcase
  endfunction

  // Called and returns at a falling edge with in_valid low
  task automatic send_key(input logic [FIELD_W-1:0] data, input logic is_last);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 14) : 0;
    repeat (gap) @(negedge clk);
    in_word.key  = data;
    in_word.last = is_last;
    in_valid     = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    load_and_sort(data, is_last);
    keys_sent++;
    if (is_last)
      sets_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_set(input logic [FIELD_W-1:0] keys[$]);
    for (int i = 0; i < keys.size(); i++)
      send_key(keys[i], i == keys.size() - 1);
  endtask

  // Write compare_mode only once the sorter has drained
  task automatic set_mode(input mode_t m);
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_data  = m;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sort_mode     = m;
    modes_used[m] = 1'b1;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_directed();
    logic [FIELD_W-1:0] corner_keys[$];
    logic [FIELD_W-1:0] desc_keys[$];
    corner_keys = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h0000_0001, 32'h0000_0000};
    desc_keys   = '{32'h0000_0005, 32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0000,
                    32'h8000_0000};
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_set(corner_keys);
    send_key(32'h1234_5678, 1'b1);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    set_mode(MODE_SIGNED_ASC);
    send_set(corner_keys);
    set_mode(MODE_UNSIGNED_DESC);
    send_set(desc_keys);
    set_mode(MODE_SIGNED_DESC);
    send_set(corner_keys);
  endtask

  task automatic test_overflow_under_hold();
    logic [FIELD_W-1:0] keys[$];
    set_mode(mode_t'($urandom_range(0, 3)));
    tx_gaps = 1'b0;
    rx_gaps = 1'b1;
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    // two keys past capacity, so the last-marked key is dropped
    for (int i = 0; i < CAP + 2; i++)
      keys.push_back(pick_key());
    send_set(keys);
    keys.delete();
    for (int i = 0; i < 6; i++)
      keys.push_back(pick_key());
    tx_gaps = 1'b1;
    send_set(keys);
  endtask

  task automatic test_random_sets();
    logic [FIELD_W-1:0] keys[$];
    int                 first_key;
    int                 set_size;
    first_key = keys_sent;
    set_mode(MODE_UNSIGNED_ASC);
    while (keys_sent - first_key < RANDOM_KEYS) begin
      if ($urandom_range(0, 2) == 0)
        set_mode(mode_t'($urandom_range(0, 3)));
      tx_gaps  = ($urandom_range(0, 3) != 0);
      rx_gaps  = ($urandom_range(0, 3) != 0);
      set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
      keys.delete();
      for (int i = 0; i < set_size; i++)
        keys.push_back(pick_key());
      send_set(keys);
    end
  endtask

  // Output side: long hold on request, else a fresh random stall per word
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (rx_gap_left > 0) begin
      out_stall = 1'b1;
      rx_gap_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin : check_word
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_checked++;
      rx_gap_left = rx_gaps ? $urandom_range(0, 14) : 0;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: key %h final %b overflow %b",
                   out_word.sorted_key, out_word.final_res, out_word.overflowed);
      end else begin
        want = pending_words.pop_front();
        if (out_word.sorted_key !== want.sorted_key || out_word.final_res !== want.final_res ||
            out_word.overflowed !== want.overflowed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected key %h final %b overflow %b, got key %h final %b overflow %b",
                     words_checked, want.sorted_key, want.final_res, want.overflowed,
                     out_word.sorted_key, out_word.final_res, out_word.overflowed);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles, %0d words outstanding",
               quiet_cycles, pending_words.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_overflow_under_hold();
    test_random_sets();
    while (pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("sorted %0d sets from %0d keys (%0d with dropped keys), %0d words checked",
             sets_sent, keys_sent, overflow_sets, words_checked);
    $display("compare modes exercised %b, mismatches %0d", modes_used, mismatches);
    if (mismatches == 0 && pending_words.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
